@@ design/assert_macros.svh @@
// Assertion macros used by the top-level design file.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Implication checked on every rising edge outside reset.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

@@ design/edq_pkg.sv @@
package edq_pkg;

  // CORDIC working word: signed Q2.30.
  typedef logic signed [31:0] q30_t;
  // CORDIC residual angle in units of 2^-24 degrees.
  typedef logic signed [32:0] resid_t;
  // Full-precision product of two working words.
  typedef logic signed [63:0] prod_t;

  localparam int unsigned IN_W      = 20;
  localparam int unsigned OUT_W     = 16;
  localparam int unsigned RES_FRAC  = 24;
  localparam int unsigned WORK_FRAC = 30;

  // Reciprocal of the CORDIC gain in Q30.
  localparam q30_t CORDIC_GAIN = 32'sd652032874;

  // atan(2^-i) in degrees, units of 2^-24, rounded to nearest.
  localparam logic [31:0] ATAN_Q24 [32] = '{
    32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
    32'd30029717, 32'd15018523, 32'd7509720, 32'd3754917, 32'd1877466,
    32'd938734, 32'd469367, 32'd234684, 32'd117342, 32'd58671, 32'd29335,
    32'd14668, 32'd7334, 32'd3667, 32'd1833, 32'd917, 32'd458, 32'd229,
    32'd115, 32'd57, 32'd29, 32'd14, 32'd7, 32'd4, 32'd2, 32'd1, 32'd0
  };

endpackage

@@ design/euler_degrees_to_quaternion_unit.sv @@
// Converts three Euler angles in degrees (signed, ANGLE_FRAC_BITS fraction bits) into the
// unit quaternion qz * (qx * qy), given as x, y, z and w in signed fixed point with
// OUT_FRAC_BITS fraction bits, saturated to 16 bits so that 1.0 reads as 32767 by default.
// The unit is a single pipeline with no state between items: one angle triple may be
// transferred in every cycle while in_stall is low, and its result passes through one
// register stage for each CORDIC iteration plus four for angle reduction and six for
// the quadrant map, the two quaternion products and the output rounding. The whole
// pipeline advances together; it holds only while a finished result waits on out_stall,
// and in_stall is raised for exactly those cycles.
module euler_degrees_to_quaternion_unit
  import edq_pkg::*;
#(
  parameter int unsigned ANGLE_FRAC_BITS   = 8,
  parameter int unsigned OUT_FRAC_BITS     = 15,
  parameter int unsigned CORDIC_ITERATIONS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [IN_W-1:0]   in_angle_x_deg,
  input  logic signed [IN_W-1:0]   in_angle_y_deg,
  input  logic signed [IN_W-1:0]   in_angle_z_deg,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [OUT_W-1:0]  out_quat_x,
  output logic signed [OUT_W-1:0]  out_quat_y,
  output logic signed [OUT_W-1:0]  out_quat_z,
  output logic signed [OUT_W-1:0]  out_quat_w
);

  // One turn of the half angle is 720 degrees of the full angle.
  localparam longint unsigned TURN    = 64'd720 << ANGLE_FRAC_BITS;
  localparam longint unsigned QUARTER = 64'd180 << ANGLE_FRAC_BITS;
  // Offset of whole turns that makes every input non-negative.
  localparam longint unsigned KTURNS  = ((64'd1 << (IN_W - 1)) + TURN - 64'd1) / TURN;
  localparam longint unsigned OFFSET  = KTURNS * TURN;
  // Reciprocal of the turn for the modulo, exact over the whole offset range.
  localparam int unsigned     RSH     = 44;
  localparam longint unsigned RECIP   = ((64'd1 << RSH) + TURN - 64'd1) / TURN;
  localparam int unsigned     U_W     = 22;
  localparam int unsigned     QT_W    = 9;
  localparam int unsigned     M_W     = 31;
  localparam int unsigned     P_W     = U_W + M_W;
  localparam int unsigned     ZSH     = RES_FRAC - ANGLE_FRAC_BITS - 1;
  localparam int unsigned     NIT     = CORDIC_ITERATIONS;
  localparam int unsigned     LAT     = NIT + 10;
  localparam int unsigned     OSH     = WORK_FRAC - OUT_FRAC_BITS;
  localparam int unsigned     W_W     = 35;
  localparam longint          ORND    = (OSH == 0) ? 64'sd0 : (64'sd1 <<< (OSH - 1));

  logic en;
  logic [LAT-1:0] vld_r;

  // The pipeline moves unless the output register holds a result that is stalled.
  assign en       = !(vld_r[LAT-1] && out_stall);
  assign in_stall = !en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // Stage 1: shift each angle into the non-negative range by whole turns.
  logic signed [IN_W-1:0] ang [3];
  logic [U_W-1:0] u_nxt [3];
  logic [U_W-1:0] u_r   [3];

  assign ang[0] = in_angle_x_deg;
  assign ang[1] = in_angle_y_deg;
  assign ang[2] = in_angle_z_deg;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      u_nxt[a] = U_W'($signed({{(U_W + 1 - IN_W){ang[a][IN_W-1]}}, ang[a]})
                      + $signed({1'b0, U_W'(OFFSET)}));
    end
  end

  // Stage 2: number of whole turns by multiplication with the reciprocal.
  logic [P_W-1:0]  prod_turn [3];
  logic [QT_W-1:0] qt_nxt    [3];
  logic [QT_W-1:0] qt_r      [3];
  logic [U_W-1:0]  u2_r      [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      prod_turn[a] = P_W'(u_r[a]) * P_W'(M_W'(RECIP));
      qt_nxt[a]    = prod_turn[a][RSH +: QT_W];
    end
  end

  // Stage 3: the remainder, the angle reduced into [0, 720) degrees, one turn of the half angle.
  logic [U_W-1:0] h_nxt [3];
  logic [U_W-1:0] h_r   [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      h_nxt[a] = u2_r[a] - U_W'(U_W'(qt_r[a]) * U_W'(TURN));
    end
  end

  // Stage 4: quadrant and residual angle for the CORDIC.
  logic [1:0]     quad_nxt [3];
  logic [U_W-1:0] rem      [3];
  resid_t         z0_nxt   [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (h_r[a] >= U_W'(3 * QUARTER)) begin
        quad_nxt[a] = 2'd3;
        rem[a]      = h_r[a] - U_W'(3 * QUARTER);
      end else if (h_r[a] >= U_W'(2 * QUARTER)) begin
        quad_nxt[a] = 2'd2;
        rem[a]      = h_r[a] - U_W'(2 * QUARTER);
      end else if (h_r[a] >= U_W'(QUARTER)) begin
        quad_nxt[a] = 2'd1;
        rem[a]      = h_r[a] - U_W'(QUARTER);
      end else begin
        quad_nxt[a] = 2'd0;
        rem[a]      = h_r[a];
      end
      z0_nxt[a] = resid_t'(rem[a]) <<< ZSH;
    end
  end

  // CORDIC registers: index 0 is the stage 4 output, index i + 1 follows iteration i.
  q30_t       cx_r   [NIT+1][3];
  q30_t       cy_r   [NIT+1][3];
  resid_t     cz_r   [NIT+1][3];
  logic [1:0] quad_r [NIT+1][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        u_r[a]       <= u_nxt[a];
        qt_r[a]      <= qt_nxt[a];
        u2_r[a]      <= u_r[a];
        h_r[a]       <= h_nxt[a];
        quad_r[0][a] <= quad_nxt[a];
        cz_r[0][a]   <= z0_nxt[a];
        cx_r[0][a]   <= CORDIC_GAIN;
        cy_r[0][a]   <= '0;
      end
    end
  end

  // One rotation step per stage; the shift and table entry are fixed per stage.
  for (genvar i = 0; i < NIT; i++) begin : g_cordic
    q30_t   cx_nxt [3];
    q30_t   cy_nxt [3];
    resid_t cz_nxt [3];

    always_comb begin
      for (int a = 0; a < 3; a++) begin
        if (!cz_r[i][a][32]) begin
          cx_nxt[a] = cx_r[i][a] - (cy_r[i][a] >>> (i % 32));
          cy_nxt[a] = cy_r[i][a] + (cx_r[i][a] >>> (i % 32));
          cz_nxt[a] = cz_r[i][a] - $signed({1'b0, ATAN_Q24[i % 32]});
        end else begin
          cx_nxt[a] = cx_r[i][a] + (cy_r[i][a] >>> (i % 32));
          cy_nxt[a] = cy_r[i][a] - (cx_r[i][a] >>> (i % 32));
          cz_nxt[a] = cz_r[i][a] + $signed({1'b0, ATAN_Q24[i % 32]});
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int a = 0; a < 3; a++) begin
          cx_r[i+1][a]   <= cx_nxt[a];
          cy_r[i+1][a]   <= cy_nxt[a];
          cz_r[i+1][a]   <= cz_nxt[a];
          quad_r[i+1][a] <= quad_r[i][a];
        end
      end
    end
  end

  // Quadrant map to the cosine and sine of the half angle.
  q30_t co_nxt [3];
  q30_t si_nxt [3];
  q30_t co_r   [3];
  q30_t si_r   [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      case (quad_r[NIT][a])
        2'd0: begin
          co_nxt[a] = cx_r[NIT][a];
          si_nxt[a] = cy_r[NIT][a];
        end
        2'd1: begin
          co_nxt[a] = -cy_r[NIT][a];
          si_nxt[a] = cx_r[NIT][a];
        end
        2'd2: begin
          co_nxt[a] = -cx_r[NIT][a];
          si_nxt[a] = -cy_r[NIT][a];
        end
        default: begin
          co_nxt[a] = cy_r[NIT][a];
          si_nxt[a] = -cx_r[NIT][a];
        end
      endcase
    end
  end

  // First product qx * qy: only one term of each component is non-zero.
  // Component order is x, y, z, w throughout.
  prod_t m1_nxt [4];
  prod_t m1_r   [4];
  q30_t  cz1_r, sz1_r, cz2_r, sz2_r;

  always_comb begin
    m1_nxt[0] = si_r[0] * co_r[1];
    m1_nxt[1] = co_r[0] * si_r[1];
    m1_nxt[2] = si_r[0] * si_r[1];
    m1_nxt[3] = co_r[0] * co_r[1];
  end

  // Round the first product back to Q30.
  q30_t  p_nxt [4];
  q30_t  p_r   [4];
  prod_t p_sum [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      p_sum[c] = m1_r[c] + (64'sd1 <<< (WORK_FRAC - 1));
      p_nxt[c] = p_sum[c][WORK_FRAC +: 32];
    end
  end

  // Second product qz * p: two non-zero terms per component.
  prod_t ma_nxt [4];
  prod_t mb_nxt [4];
  prod_t ma_r   [4];
  prod_t mb_r   [4];

  always_comb begin
    ma_nxt[0] = cz2_r * p_r[0];
    mb_nxt[0] = -(sz2_r * p_r[1]);
    ma_nxt[1] = cz2_r * p_r[1];
    mb_nxt[1] = sz2_r * p_r[0];
    ma_nxt[2] = cz2_r * p_r[2];
    mb_nxt[2] = sz2_r * p_r[3];
    ma_nxt[3] = cz2_r * p_r[3];
    mb_nxt[3] = -(sz2_r * p_r[2]);
  end

  // Sum the two terms and round to Q30.
  logic signed [64:0]    s2    [4];
  logic signed [W_W-1:0] w_nxt [4];
  logic signed [W_W-1:0] w_r   [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      s2[c]    = 65'(ma_r[c]) + 65'(mb_r[c]) + (65'sd1 <<< (WORK_FRAC - 1));
      w_nxt[c] = s2[c][WORK_FRAC +: W_W];
    end
  end

  // Output scaling with round half up, then saturation to 16 bits.
  logic signed [W_W:0]    o_rnd [4];
  logic signed [W_W:0]    o_shf [4];
  logic signed [OUT_W-1:0] q_nxt [4];
  logic signed [OUT_W-1:0] q_r   [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      o_rnd[c] = (W_W + 1)'(w_r[c]) + (W_W + 1)'(ORND);
      o_shf[c] = o_rnd[c] >>> OSH;
      if (o_shf[c] > (W_W + 1)'(32767)) begin
        q_nxt[c] = 16'sh7fff;
      end else if (o_shf[c] < -(W_W + 1)'(32768)) begin
        q_nxt[c] = -16'sh8000;
      end else begin
        q_nxt[c] = o_shf[c][OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        co_r[a] <= co_nxt[a];
        si_r[a] <= si_nxt[a];
      end
      cz1_r <= co_r[2];
      sz1_r <= si_r[2];
      cz2_r <= cz1_r;
      sz2_r <= sz1_r;
      for (int c = 0; c < 4; c++) begin
        m1_r[c] <= m1_nxt[c];
        p_r[c]  <= p_nxt[c];
        ma_r[c] <= ma_nxt[c];
        mb_r[c] <= mb_nxt[c];
        w_r[c]  <= w_nxt[c];
        q_r[c]  <= q_nxt[c];
      end
    end
  end

  assign out_quat_x = q_r[0];
  assign out_quat_y = q_r[1];
  assign out_quat_z = q_r[2];
  assign out_quat_w = q_r[3];

`include "assert_macros.svh"

  `ASSERT_IMPLY(a_hold_in, clk, rst_n, out_valid && out_stall, in_stall, "input taken while output held")
  `ASSERT_NEXT(a_load, clk, rst_n, in_valid && !in_stall, vld_r[0], "accepted transfer lost at entry")
  `ASSERT_IMPLY(a_drop, clk, rst_n, $fell(out_valid), $past(!out_stall), "result dropped while stalled")

endmodule

@@ tb/tb_euler_degrees_to_quaternion_unit.sv @@
module tb_euler_degrees_to_quaternion_unit
  import edq_pkg::*;
();

  localparam int ANGLE_FRAC = 8;
  localparam int OUT_FRAC   = 15;
  localparam int ITERS      = 16;
  // Pipeline depth as given at the head of the top level.
  localparam int LATENCY    = ITERS + 10;
  localparam int IDLE_LIMIT = 20000;
  localparam int N_RANDOM   = 1330;

  typedef struct packed {
    logic signed [IN_W-1:0] ax;
    logic signed [IN_W-1:0] ay;
    logic signed [IN_W-1:0] az;
  } angles_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] qx;
    logic signed [OUT_W-1:0] qy;
    logic signed [OUT_W-1:0] qz;
    logic signed [OUT_W-1:0] qw;
  } quat_out_t;

  typedef struct {
    longint vx;
    longint vy;
    longint vz;
    longint sc;
  } quat_wide_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [IN_W-1:0] in_angle_x_deg;
  logic signed [IN_W-1:0] in_angle_y_deg;
  logic signed [IN_W-1:0] in_angle_z_deg;
  logic out_valid;
  logic out_stall;
  logic signed [OUT_W-1:0] out_quat_x;
  logic signed [OUT_W-1:0] out_quat_y;
  logic signed [OUT_W-1:0] out_quat_z;
  logic signed [OUT_W-1:0] out_quat_w;

  euler_degrees_to_quaternion_unit #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC),
    .OUT_FRAC_BITS(OUT_FRAC),
    .CORDIC_ITERATIONS(ITERS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_angle_x_deg(in_angle_x_deg),
    .in_angle_y_deg(in_angle_y_deg),
    .in_angle_z_deg(in_angle_z_deg),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_quat_x(out_quat_x),
    .out_quat_y(out_quat_y),
    .out_quat_z(out_quat_z),
    .out_quat_w(out_quat_w)
  );

  // Angle triples waiting to be driven, and quaternions still owed by the block.
  angles_t   angle_queue[$];
  quat_out_t quat_expected[$];

  int  n_errors;
  int  n_sent;
  int  n_checked;
  int  idle_cycles;
  // When set, the driver holds off until every expected quaternion has arrived.
  bit  drain_req;

  // Appends one angle triple to the end of the pending queue.
  function automatic void queue_angles(angles_t a);
    angle_queue = {angle_queue, a};
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Floor shift of a signed 64-bit value; >>> on a longint is already a floor shift.
  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint shr_round(longint v, int s);
    if (s == 0) begin
      return v;
    end
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  // Cosine and sine in Q30 of half the given angle, by the same fixed-length CORDIC.
  task automatic half_angle_cos_sin(input logic signed [IN_W-1:0] angle,
                                    output longint co, output longint si);
    longint turn;
    longint quarter;
    longint h;
    longint quad;
    longint resid;
    longint cx;
    longint cy;
    longint dx;
    longint dy;
    int     k;
    turn    = longint'(720) << ANGLE_FRAC;
    quarter = longint'(90) << (ANGLE_FRAC + 1);
    h = longint'(angle) % turn;
    if (h < 0) begin
      h += turn;
    end
    quad  = h / quarter;
    resid = (h - quad * quarter) << (RES_FRAC - ANGLE_FRAC - 1);
    cx = longint'(CORDIC_GAIN);
    cy = 0;
    for (int i = 0; i < ITERS; i++) begin
      k  = i & 31;
      dx = shr_floor(cy, k);
      dy = shr_floor(cx, k);
      if (resid >= 0) begin
        cx -= dx;
        cy += dy;
        resid -= longint'(ATAN_Q24[k]);
      end else begin
        cx += dx;
        cy -= dy;
        resid += longint'(ATAN_Q24[k]);
      end
    end
    case (quad & 3)
      0: begin co = cx;  si = cy;  end
      1: begin co = -cy; si = cx;  end
      2: begin co = -cx; si = -cy; end
      default: begin co = cy; si = -cx; end
    endcase
  endtask

  function automatic quat_wide_t hamilton_q30(quat_wide_t l, quat_wide_t r);
    quat_wide_t o;
    o.vx = shr_round(l.sc * r.vx + l.vx * r.sc + l.vy * r.vz - l.vz * r.vy, WORK_FRAC);
    o.vy = shr_round(l.sc * r.vy - l.vx * r.vz + l.vy * r.sc + l.vz * r.vx, WORK_FRAC);
    o.vz = shr_round(l.sc * r.vz + l.vx * r.vy - l.vy * r.vx + l.vz * r.sc, WORK_FRAC);
    o.sc = shr_round(l.sc * r.sc - l.vx * r.vx - l.vy * r.vy - l.vz * r.vz, WORK_FRAC);
    return o;
  endfunction

  function automatic logic signed [OUT_W-1:0] scale_saturate(longint v);
    longint s;
    s = shr_round(v, WORK_FRAC - OUT_FRAC);
    if (s > 32767) begin
      s = 32767;
    end
    if (s < -32768) begin
      s = -32768;
    end
    return s[OUT_W-1:0];
  endfunction

  // The rotation is composed as qz * (qx * qy).
  task automatic predict_quaternion(input angles_t a, output quat_out_t q);
    quat_wide_t rx;
    quat_wide_t ry;
    quat_wide_t rz;
    quat_wide_t prod;
    longint c;
    longint s;
    half_angle_cos_sin(a.ax, c, s);
    rx = '{s, 0, 0, c};
    half_angle_cos_sin(a.ay, c, s);
    ry = '{0, s, 0, c};
    half_angle_cos_sin(a.az, c, s);
    rz = '{0, 0, s, c};
    prod = hamilton_q30(rz, hamilton_q30(rx, ry));
    q.qx = scale_saturate(prod.vx);
    q.qy = scale_saturate(prod.vy);
    q.qz = scale_saturate(prod.vz);
    q.qw = scale_saturate(prod.sc);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on result %0d: %s got %0d expected %0d", n_checked, what, got, want);
    n_errors++;
  endtask

  // Short gaps most of the time, occasionally a long one.
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Random angle: mostly the full range, some near the wrap points of the
  // half-angle reduction and of the quadrants.
  function automatic logic signed [IN_W-1:0] random_angle();
    int r;
    int base;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      return IN_W'($urandom());
    end
    base = 90 * $signed($urandom_range(0, 11)) - 540;
    return IN_W'((base <<< ANGLE_FRAC) + $signed($urandom_range(0, 6)) - 3);
  endfunction

  // Driver: a transfer happens when valid is high and stall is low at the edge.
  // Valid stays high without a dip across back-to-back transfers.
  int send_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        quat_out_t q;
        predict_quaternion({in_angle_x_deg, in_angle_y_deg, in_angle_z_deg}, q);
        quat_expected = {quat_expected, q};
        n_sent++;
      end
      if (in_valid && in_stall) begin
        // The payload is held while stalled.
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (angle_queue.size() != 0 &&
                   !(drain_req && (quat_expected.size() != 0 ||
                                   (in_valid && !in_stall)))) begin
        angles_t a;
        a = angle_queue.pop_front();
        in_valid       <= 1'b1;
        in_angle_x_deg <= a.ax;
        in_angle_y_deg <= a.ay;
        in_angle_z_deg <= a.az;
        send_gap       <= gap_length();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compares each accepted quaternion with the oldest prediction and
  // drives a random stall pattern on the result side.
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (quat_expected.size() == 0) begin
          $display("unexpected result: x %0d y %0d z %0d w %0d",
                   out_quat_x, out_quat_y, out_quat_z, out_quat_w);
          n_errors++;
        end else begin
          quat_out_t q;
          q = quat_expected.pop_front();
          if (out_quat_x !== q.qx) report_mismatch("quat_x", out_quat_x, q.qx);
          if (out_quat_y !== q.qy) report_mismatch("quat_y", out_quat_y, q.qy);
          if (out_quat_z !== q.qz) report_mismatch("quat_z", out_quat_z, q.qz);
          if (out_quat_w !== q.qw) report_mismatch("quat_w", out_quat_w, q.qw);
        end
        n_checked++;
      end
      if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        int g;
        g = gap_length();
        out_stall  <= (g != 0);
        stall_left <= (g != 0) ? g - 1 : 0;
      end
    end
  end

  // Watchdog: counts cycles in which no transfer takes place on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired: %0d sent, %0d checked", n_sent, n_checked);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic angles_t triple(int x, int y, int z);
    angles_t a;
    a.ax = IN_W'(x);
    a.ay = IN_W'(y);
    a.az = IN_W'(z);
    return a;
  endfunction

  initial begin
    int one_deg;
    n_errors    = 0;
    n_sent      = 0;
    n_checked   = 0;
    drain_req   = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_angle_x_deg = '0;
    in_angle_y_deg = '0;
    in_angle_z_deg = '0;
    out_stall      = 1'b0;
    one_deg = 1 << ANGLE_FRAC;

    // Directed triples: field extremes, exact quadrant boundaries, one turn of
    // the half angle and its wrap, and the saturation of 1.0 at zero rotation.
    queue_angles(triple(0, 0, 0));
    queue_angles(triple(-524288, -524288, -524288));
    queue_angles(triple(524287, 524287, 524287));
    queue_angles(triple(-524288, 0, 524287));
    queue_angles(triple(180 * one_deg, 0, 0));
    queue_angles(triple(0, 180 * one_deg, 0));
    queue_angles(triple(0, 0, 180 * one_deg));
    queue_angles(triple(360 * one_deg, 360 * one_deg, 360 * one_deg));
    queue_angles(triple(540 * one_deg, -540 * one_deg, 540 * one_deg));
    queue_angles(triple(720 * one_deg, -720 * one_deg, 0));
    queue_angles(triple(720 * one_deg - 1, 1, -1));
    queue_angles(triple(90 * one_deg, 90 * one_deg, 90 * one_deg));
    queue_angles(triple(-90 * one_deg, 45 * one_deg, -45 * one_deg));
    queue_angles(triple(30 * one_deg, 60 * one_deg, 120 * one_deg));
    queue_angles(triple(1, 1, 1));
    queue_angles(triple(-1, -1, -1));
    queue_angles(triple(179 * one_deg + 255, 359 * one_deg + 255, 0));
    queue_angles(triple(21845, -349525, 174762));
    queue_angles(triple(-174763, 349524, -21846));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // First half of the random triples, then a full drain, then the rest.
    for (int i = 0; i < N_RANDOM / 2; i++) begin
      queue_angles(triple(random_angle(), random_angle(), random_angle()));
    end
    wait (angle_queue.size() == 0);
    drain_req = 1'b1;
    for (int i = 0; i < N_RANDOM - N_RANDOM / 2; i++) begin
      queue_angles(triple(random_angle(), random_angle(), random_angle()));
    end
    @(posedge clk);
    wait (quat_expected.size() == 0 && !(in_valid && !in_stall));
    @(posedge clk);
    drain_req = 1'b0;

    wait (angle_queue.size() == 0);
    @(posedge clk);
    while (in_valid) @(posedge clk);
    wait (quat_expected.size() == 0);
    repeat (LATENCY + 50) @(posedge clk);

    $display("covered %0d angle triples, %0d quaternions checked, %0d mismatches",
             n_sent, n_checked, n_errors);
    $display("stimulus: field extremes, quadrant and wrap boundaries, random angles");
    if (n_errors == 0 && quat_expected.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
